// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes for the buddy block allocator: node flag encoding,
// result status codes and the fixed field widths of the request and response
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int SIZE_W   = 17;
  localparam int OFFSET_W = 16;
  localparam int CLASS_W  = 3;
  localparam int STATUS_W = 2;

  typedef logic [1:0]          flag_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam flag_t FLAG_FREE  = 2'b00;
  localparam flag_t FLAG_SPLIT = 2'b01;
  localparam flag_t FLAG_USED  = 2'b10;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NO_SPACE = 2'd1;
  localparam status_t STATUS_BAD_SIZE = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

endpackage

// ===== design/bba_req_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if
// request channel: allocate or free transaction with size and offset
// ----------------------------------------------------------------------------
interface bba_req_if;
  import bba_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [SIZE_W-1:0]   request_size;
  logic [OFFSET_W-1:0] free_offset;

  modport source (output valid, output action, output request_size, output free_offset,
                  input ready);
  modport sink (input valid, input action, input request_size, input free_offset,
                output ready);
endinterface

// ----------------------------------------------------------------------------
// bba_rsp_if
// response channel: status, block offset and size class of one transaction
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  import bba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] block_offset;
  logic [CLASS_W-1:0]  size_class;

  modport source (output valid, output status, output block_offset, output size_class,
                  input ready);
  modport sink (input valid, input status, input block_offset, input size_class,
                output ready);
endinterface

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic synchronous ram, one write port and two read ports, registered read
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/bba_class.sv =====
// ----------------------------------------------------------------------------
// bba_class
// size decode: flags a zero or oversized request and rounds the size up to
// the deepest tree level whose block still holds it
// ----------------------------------------------------------------------------
module bba_class #(
  parameter int POOL_LOG2 = 16,
  parameter int MAX_DEPTH = 6
) (
  input  logic [bba_pkg::SIZE_W-1:0]       request_size,
  output logic                             bad,
  output logic [$clog2(MAX_DEPTH+1)-1:0]   lvl
);
  import bba_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int CW = (POOL_LOG2 + 1 > SIZE_W) ? POOL_LOG2 + 1 : SIZE_W;
  localparam logic [CW-1:0] POOL_BYTES = CW'(1) << POOL_LOG2;

  logic [CW-1:0] size_ext;
  logic [LW-1:0] lvl_c;

  assign size_ext = CW'(request_size);
  assign bad      = (request_size == '0) || (size_ext > POOL_BYTES);

  always_comb begin
    lvl_c = '0;
    for (int l = 1; l <= MAX_DEPTH; l++) begin
      if (size_ext <= (POOL_BYTES >> l)) begin
        lvl_c = LW'(l);
      end
    end
  end

  assign lvl = bad ? '0 : lvl_c;

endmodule

// ===== design/buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator over a pool of 2^POOL_LOG2 bytes, node flags kept in ram
// ----------------------------------------------------------------------------
// The pool is a binary tree of MAX_DEPTH+1 levels whose 2-bit node flags
// (split, used) live in one ram of 2^(MAX_DEPTH+1)-1 entries. After reset the
// block clears that ram, one entry a cycle, and takes no request meanwhile.
// A request is handled one at a time: an allocate walks down the tree one
// level per cycle, both children read together, and then writes the
// ancestors back one level per cycle on the way up; a free writes its node
// and its ancestors back the same way, and a bad size or a failed allocate
// goes straight to the response. The next request is accepted as soon as the
// response is loaded, even while it is still waiting to be taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
  parameter int POOL_LOG2 = 16,
  parameter int MAX_DEPTH = 6
) (
  input  logic  clk,
  input  logic  rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  localparam int LW         = $clog2(MAX_DEPTH + 1);
  localparam int NW         = MAX_DEPTH + 1;
  localparam int NODE_COUNT = 2 ** (MAX_DEPTH + 1) - 1;
  localparam int OW         = (POOL_LOG2 > OFFSET_W) ? POOL_LOG2 : OFFSET_W;
  localparam int SHW        = $clog2(POOL_LOG2 + 1);
  localparam logic [OW-1:0] OFF_MASK = {OW{1'b1}} >> (OW - POOL_LOG2);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SETUP   = 4'd2;
  localparam logic [3:0] S_ROOTCHK = 4'd3;
  localparam logic [3:0] S_DESC    = 4'd4;
  localparam logic [3:0] S_WRN     = 4'd5;
  localparam logic [3:0] S_UPD     = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;

  function automatic logic [NW-1:0] buddy_of(input logic [NW-1:0] n);
    return n[0] ? n + NW'(1) : n - NW'(1);
  endfunction

  function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] n);
    return (n - NW'(1)) >> 1;
  endfunction

  // registers
  logic [3:0]          state, state_next;
  logic [NW-1:0]       clr_cnt, clr_cnt_next;
  logic                act, act_next;
  logic                bad, bad_next;
  logic [LW-1:0]       lvl, lvl_next;
  logic [OFFSET_W-1:0] off, off_next;
  logic [NW-1:0]       node, node_next;
  logic [LW-1:0]       dl, dl_next;
  flag_t               own, own_next;
  status_t             res_status, res_status_next;
  logic [OFFSET_W-1:0] res_off, res_off_next;
  logic                rsp_valid, rsp_valid_next;
  status_t             rsp_status, rsp_status_next;
  logic [OFFSET_W-1:0] rsp_off, rsp_off_next;
  logic [CLASS_W-1:0]  rsp_class, rsp_class_next;

  // ram ports
  logic          we;
  logic [NW-1:0] waddr, raddr_a, raddr_b;
  flag_t         wdata, rdata_a, rdata_b;

  // size decode
  logic          dec_bad;
  logic [LW-1:0] dec_lvl;

  // datapath
  logic [SHW-1:0] sh;
  logic [OW-1:0]  idx;
  logic [NW-1:0]  free_node;
  logic [NW-1:0]  level_base;
  logic [NW-1:0]  take_node;
  logic [NW-1:0]  take_pos;
  logic [OW-1:0]  take_off;
  logic [NW-1:0]  child_l, child_r;
  logic           last_level;

  bba_class #(
    .POOL_LOG2 (POOL_LOG2),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_class (
    .request_size (req.request_size),
    .bad          (dec_bad),
    .lvl          (dec_lvl)
  );

  bba_ram #(
    .WIDTH ($bits(flag_t)),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign sh         = SHW'(POOL_LOG2) - SHW'(lvl);
  assign level_base = (NW'(1) << lvl) - NW'(1);
  assign idx        = (OW'(off) & OFF_MASK) >> sh;
  assign free_node  = NW'(idx) + level_base;
  assign child_l    = (node << 1) + NW'(1);
  assign child_r    = (node << 1) + NW'(2);
  assign last_level = ((dl + LW'(1)) == lvl);
  assign take_pos   = take_node - level_base;
  assign take_off   = OW'(take_pos) << sh;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.block_offset = rsp_off;
  assign rsp.size_class   = rsp_class;

  always_comb begin
    flag_t own_new;
    logic  rsp_free;
    logic  take;
    logic  fail;

    state_next      = state;
    clr_cnt_next    = clr_cnt;
    act_next        = act;
    bad_next        = bad;
    lvl_next        = lvl;
    off_next        = off;
    node_next       = node;
    dl_next         = dl;
    own_next        = own;
    res_status_next = res_status;
    res_off_next    = res_off;
    rsp_status_next = rsp_status;
    rsp_off_next    = rsp_off;
    rsp_class_next  = rsp_class;
    we              = 1'b0;
    waddr           = node;
    wdata           = own;
    raddr_a         = '0;
    raddr_b         = '0;
    take_node       = '0;
    take            = 1'b0;
    fail            = 1'b0;
    own_new         = own;
    rsp_free        = !rsp_valid || rsp.ready;
    rsp_valid_next  = rsp_valid && !rsp.ready;

    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = FLAG_FREE;
        if (clr_cnt == NW'(NODE_COUNT - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + NW'(1);
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          act_next   = req.action;
          bad_next   = dec_bad;
          lvl_next   = dec_lvl;
          off_next   = req.free_offset;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        res_off_next = '0;
        if (bad) begin
          res_status_next = STATUS_BAD_SIZE;
          state_next      = S_FIN;
        end else if (act == ACTION_FREE) begin
          res_status_next = STATUS_OK;
          node_next       = free_node;
          own_next        = FLAG_FREE;
          state_next      = S_WRN;
        end else begin
          raddr_a    = '0;
          state_next = S_ROOTCHK;
        end
      end
      S_ROOTCHK: begin
        if (lvl == '0) begin
          if (rdata_a == FLAG_FREE) begin
            take      = 1'b1;
            take_node = '0;
          end else begin
            fail = 1'b1;
          end
        end else if ((rdata_a & FLAG_USED) != FLAG_FREE) begin
          fail = 1'b1;
        end else begin
          node_next  = '0;
          dl_next    = '0;
          raddr_a    = NW'(1);
          raddr_b    = NW'(2);
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        if (last_level) begin
          if (rdata_a == FLAG_FREE) begin
            take      = 1'b1;
            take_node = child_l;
          end else if (rdata_b == FLAG_FREE) begin
            take      = 1'b1;
            take_node = child_r;
          end else begin
            fail = 1'b1;
          end
        end else if ((rdata_a & FLAG_USED) == FLAG_FREE) begin
          node_next = child_l;
          dl_next   = dl + LW'(1);
          raddr_a   = (child_l << 1) + NW'(1);
          raddr_b   = (child_l << 1) + NW'(2);
        end else if ((rdata_b & FLAG_USED) == FLAG_FREE) begin
          node_next = child_r;
          dl_next   = dl + LW'(1);
          raddr_a   = (child_r << 1) + NW'(1);
          raddr_b   = (child_r << 1) + NW'(2);
        end else begin
          fail = 1'b1;
        end
      end
      S_WRN: begin
        we    = 1'b1;
        waddr = node;
        wdata = own;
        if (node == '0) begin
          state_next = S_FIN;
        end else begin
          raddr_a    = buddy_of(node);
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (act == ACTION_FREE) begin
          own_new = (rdata_a != FLAG_FREE) ? (own | FLAG_SPLIT) : own;
        end else begin
          own_new = ((own & rdata_a & FLAG_USED) != FLAG_FREE) ? (FLAG_SPLIT | FLAG_USED)
                                                              : FLAG_SPLIT;
        end
        we        = 1'b1;
        waddr     = parent_of(node);
        wdata     = own_new;
        own_next  = own_new;
        node_next = parent_of(node);
        if (parent_of(node) == '0) begin
          state_next = S_FIN;
        end else begin
          raddr_a = buddy_of(parent_of(node));
        end
      end
      S_FIN: begin
        if (rsp_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_off_next    = res_off;
          rsp_class_next  = CLASS_W'(lvl);
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (take) begin
      node_next       = take_node;
      own_next        = FLAG_USED;
      res_status_next = STATUS_OK;
      res_off_next    = take_off[OFFSET_W-1:0];
      state_next      = S_WRN;
    end
    if (fail) begin
      res_status_next = STATUS_NO_SPACE;
      res_off_next    = '0;
      state_next      = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
    act        <= act_next;
    bad        <= bad_next;
    lvl        <= lvl_next;
    off        <= off_next;
    node       <= node_next;
    dl         <= dl_next;
    own        <= own_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
    rsp_status <= rsp_status_next;
    rsp_off    <= rsp_off_next;
    rsp_class  <= rsp_class_next;
  end

endmodule
